>>> rtl/ckl_pkg.sv
package ckl_pkg;

    localparam int LFSR_COUNT     = 4;
    localparam int LFSR_W         = 32;
    localparam int OUTPUT_WORDS   = 2;
    localparam int BITS_PER_WORD  = 64;
    localparam int RESULT_W       = 64;
    localparam int STEPS_PER_CELL = 8;

    localparam int TOTAL_STEPS = OUTPUT_WORDS * BITS_PER_WORD;
    localparam int NUM_CELLS   = (TOTAL_STEPS + STEPS_PER_CELL - 1) / STEPS_PER_CELL;
    localparam int KS_W        = NUM_CELLS * STEPS_PER_CELL;
    localparam int WORD_IDX_W  = (OUTPUT_WORDS > 1) ? $clog2(OUTPUT_WORDS) : 1;

    typedef logic [LFSR_W-1:0]   t_lfsr;
    typedef logic [RESULT_W-1:0] t_word;

    // Payload carried from cell to cell: running states, fixed tap masks and
    // keystream bits gathered so far (newest at the top, shifted down).
    typedef struct packed {
        logic [LFSR_COUNT-1:0][LFSR_W-1:0] state;
        logic [LFSR_COUNT-1:0][LFSR_W-1:0] taps;
        logic [KS_W-1:0]                   ks;
    } t_lane;

    typedef struct packed {
        logic  valid;
        t_lane data;
    } t_stage;

endpackage

>>> rtl/ckl_if.sv
interface ckl_seed_if;
    logic                  valid;
    logic                  ready;
    logic [ckl_pkg::LFSR_W-1:0] seed_word_0;
    logic [ckl_pkg::LFSR_W-1:0] seed_word_1;
    logic [ckl_pkg::LFSR_W-1:0] seed_word_2;
    logic [ckl_pkg::LFSR_W-1:0] seed_word_3;

    modport source (output valid, output seed_word_0, output seed_word_1,
                    output seed_word_2, output seed_word_3, input ready);
    modport sink   (input valid, input seed_word_0, input seed_word_1,
                    input seed_word_2, input seed_word_3, output ready);
endinterface

interface ckl_word_if;
    logic                         valid;
    logic                         ready;
    logic [ckl_pkg::RESULT_W-1:0] random_word;
    logic                         last_word;

    modport source (output valid, output random_word, output last_word, input ready);
    modport sink   (input valid, input random_word, input last_word, output ready);
endinterface

>>> rtl/ckl_cell.sv
module ckl_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ckl_pkg::t_stage i_stage,
    output ckl_pkg::t_stage o_stage
);
    import ckl_pkg::*;

    logic  r_valid;
    t_lane r_data;
    t_lane n_data;

    always_comb begin
        logic [LFSR_COUNT-1:0][LFSR_W-1:0] st;
        logic [STEPS_PER_CELL-1:0]         bits;
        logic                              fb;
        st   = i_stage.data.state;
        bits = '0;
        // advance every register STEPS_PER_CELL times
        for (int s = 0; s < STEPS_PER_CELL; s++) begin
            for (int j = 0; j < LFSR_COUNT; j++) begin
                bits[s] = bits[s] ^ st[j][0];
                fb      = ^(st[j] & i_stage.data.taps[j]);
                st[j]   = {fb, st[j][LFSR_W-1:1]};
            end
        end
        n_data.state = st;
        n_data.taps  = i_stage.data.taps;
        n_data.ks    = (i_stage.data.ks >> STEPS_PER_CELL)
                     | (KS_W'(bits) << (KS_W - STEPS_PER_CELL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

>>> rtl/ckl_serializer.sv
module ckl_serializer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ckl_pkg::KS_W-1:0]   i_ks,
    output logic                       o_free,
    ckl_word_if.source                 o_word_ch
);
    import ckl_pkg::*;

    logic                   r_valid;
    logic [WORD_IDX_W-1:0]  r_idx;
    logic [TOTAL_STEPS-1:0] r_ks;
    logic                   w_last;
    logic                   w_xfer;

    assign w_last = (r_idx == WORD_IDX_W'(OUTPUT_WORDS - 1));
    assign w_xfer = r_valid && o_word_ch.ready;
    assign o_free = !r_valid || (w_xfer && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_free) begin
            r_valid <= i_valid;
            r_idx   <= '0;
        end else if (w_xfer) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // load a finished keystream, then drop one word per transfer
    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_ks <= i_ks[TOTAL_STEPS-1:0];
        end else if (w_xfer) begin
            r_ks <= r_ks >> BITS_PER_WORD;
        end
    end

    assign o_word_ch.valid       = r_valid;
    assign o_word_ch.random_word = RESULT_W'(r_ks[BITS_PER_WORD-1:0]);
    assign o_word_ch.last_word   = w_last;

endmodule

>>> rtl/combined_lfsr_keystream.sv
// Path: a seed passes through the NUM_CELLS cell registers, then the serializer
// register, which gives its words one per transfer. Throughput: one seed per cycle
// into the cell chain (8 LFSR steps per cell) while the chain is not held; a steady
// stream takes OUTPUT_WORDS (2) transfers per seed. Reset clears all valid flags;
// no state spans seeds.
module combined_lfsr_keystream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckl_seed_if.sink   i_seed_ch,
    ckl_word_if.source o_word_ch
);
    import ckl_pkg::*;

    t_stage stage [NUM_CELLS+1];
    logic   w_free;
    logic   w_en;

    // hold the whole chain only when the last cell is full and cannot unload
    assign w_en            = w_free || !stage[NUM_CELLS].valid;
    assign i_seed_ch.ready = w_en;

    assign stage[0].valid         = i_seed_ch.valid;
    assign stage[0].data.state[0] = i_seed_ch.seed_word_0;
    assign stage[0].data.state[1] = i_seed_ch.seed_word_1;
    assign stage[0].data.state[2] = i_seed_ch.seed_word_2;
    assign stage[0].data.state[3] = i_seed_ch.seed_word_3;
    assign stage[0].data.taps[0]  = i_seed_ch.seed_word_0;
    assign stage[0].data.taps[1]  = i_seed_ch.seed_word_1;
    assign stage[0].data.taps[2]  = i_seed_ch.seed_word_2;
    assign stage[0].data.taps[3]  = i_seed_ch.seed_word_3;
    assign stage[0].data.ks       = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        ckl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    ckl_serializer u_serializer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage[NUM_CELLS].valid),
        .i_ks      (stage[NUM_CELLS].data.ks),
        .o_free    (w_free),
        .o_word_ch (o_word_ch)
    );

endmodule
